[hw/rtl/tpool_pkg.sv]
// ----------------------------------------------------------------------------
// Timer pool package
// Shared widths, codes and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package tpool_pkg;

   localparam int SLOTS_DEF   = 32;
   localparam int TICK_MS_DEF = 50;
   localparam int MAX_SLOTS   = 32;

   localparam int FUNC_W = 2;
   localparam int SLOT_W = 5;
   localparam int DUR_W  = 32;
   localparam int KIND_W = 3;
   localparam int TICK_W = 27;
   localparam int DCNT_W = $clog2(DUR_W);

   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   typedef enum logic [FUNC_W-1:0] {
      FUNC_START   = 2'd0,
      FUNC_STOP    = 2'd1,
      FUNC_RESTART = 2'd2,
      FUNC_TICK    = 2'd3
   } func_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_STARTED   = 3'd0,
      KIND_STOPPED   = 3'd1,
      KIND_RESTARTED = 3'd2,
      KIND_EXPIRED   = 3'd3,
      KIND_ERROR     = 3'd4
   } kind_type;

   typedef struct packed {
      logic latch;       // capture handle, func and periodic flag
      logic div_start;   // load divider with the duration
      logic do_start;    // commit start and emit its result
      logic op_read;     // read the slot of a stop or restart
      logic do_op;       // commit stop or restart and emit
      logic scan_start;  // reset the tick scan
      logic scan_run;    // step the tick scan
      logic flush;       // emit the held expiry as the final one
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic out_free;
      logic scan_done;
      logic pend_valid;
   } stat_type;

endpackage

[hw/rtl/tpool_if.sv]
// ----------------------------------------------------------------------------
// Timer pool channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
interface tpool_req_if;
   logic                             valid;
   logic                             ready;
   logic [tpool_pkg::FUNC_W-1:0]     func;
   logic [tpool_pkg::SLOT_W-1:0]     handle;
   logic [tpool_pkg::DUR_W-1:0]      duration_ms;
   logic                             periodic;

   modport source (output valid, func, handle, duration_ms, periodic, input ready);
   modport sink   (input valid, func, handle, duration_ms, periodic, output ready);
endinterface

interface tpool_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [tpool_pkg::KIND_W-1:0]     kind;
   logic [tpool_pkg::SLOT_W-1:0]     slot;
   logic                             last;

   modport source (output valid, kind, slot, last, input ready);
   modport sink   (input valid, kind, slot, last, output ready);
endinterface

[hw/rtl/timer_pool_with_tick_expiry_top.sv]
// Operations: a start runs a 5-step reciprocal multiply, then commits; stop and restart read
// the slot, then commit; a tick walks the tick stores one slot per cycle, unless a second expiry
// waits on a full output register, then emits its final result; each waits on output stalls.
// Throughput: one item at a time; the next is accepted once the last result is registered.
// Reset (synchronous): clears the slot active and periodic flags and the control state;
// the tick stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Timer pool with tick expiry
// Pool of tick-counted timer slots with start, stop, restart and tick expiry.
// ----------------------------------------------------------------------------
module timer_pool_with_tick_expiry_top #(
   parameter int SLOTS   = tpool_pkg::SLOTS_DEF,
   parameter int TICK_MS = tpool_pkg::TICK_MS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tpool_req_if.sink   req_ch,
   tpool_rsp_if.source rsp_ch
);

   localparam int USED = (SLOTS < tpool_pkg::MAX_SLOTS) ? SLOTS : tpool_pkg::MAX_SLOTS;

   tpool_pkg::cmd_type  cmd;
   tpool_pkg::stat_type stat;
   tpool_pkg::func_type req_func;
   tpool_pkg::kind_type rsp_kind;

   assign req_func = tpool_pkg::func_type'(req_ch.func);

   tpool_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_func),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tpool_dp #(.USED(USED), .TICK_MS(TICK_MS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_func),
      .req_handle      (req_ch.handle),
      .req_duration_ms (req_ch.duration_ms),
      .req_periodic    (req_ch.periodic),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_kind        (rsp_kind),
      .rsp_slot        (rsp_ch.slot),
      .rsp_last        (rsp_ch.last)
   );

   assign rsp_ch.kind = rsp_kind;

`ifndef NO_ASSERTIONS
   a_start_room: assert property (@(posedge clock) disable iff (reset)
      cmd.do_start |-> stat.out_free)
      else $error("start committed with output register occupied");

   a_op_room: assert property (@(posedge clock) disable iff (reset)
      cmd.do_op |-> stat.out_free)
      else $error("stop/restart committed with output register occupied");

   a_flush_pend: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |-> (stat.pend_valid && stat.out_free))
      else $error("final expiry flushed without a held expiry or room");

   a_div_scan: assert property (@(posedge clock) disable iff (reset)
      stat.div_busy |-> !cmd.scan_run)
      else $error("tick scan overlaps duration divide");
`endif

endmodule

[hw/rtl/tpool_ram.sv]
// ----------------------------------------------------------------------------
// Timer pool RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tpool_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/tpool_ctrl.sv]
// ----------------------------------------------------------------------------
// Timer pool controller
// Sequences start, stop, restart and tick operations over the datapath.
// ----------------------------------------------------------------------------
module tpool_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  tpool_pkg::func_type  req_func,
   output logic                 req_ready,
   input  tpool_pkg::stat_type  stat,
   output tpool_pkg::cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_START,
      ST_RD,
      ST_OP,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               case (req_func)
                  tpool_pkg::FUNC_START: begin
                     cmd.div_start = 1'b1;
                     state_in      = ST_DIV;
                  end
                  tpool_pkg::FUNC_STOP,
                  tpool_pkg::FUNC_RESTART: begin
                     state_in = ST_RD;
                  end
                  default: begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (!stat.div_busy) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (stat.out_free) begin
               cmd.do_start = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_RD: begin
            cmd.op_read = 1'b1;
            state_in    = ST_OP;
         end
         ST_OP: begin
            if (stat.out_free) begin
               cmd.do_op = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         ST_FLUSH: begin
            // a tick with no expiry ends without any transfer
            if (!stat.pend_valid) begin
               state_in = ST_IDLE;
            end else if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/tpool_dp.sv]
// ----------------------------------------------------------------------------
// Timer pool datapath
// Slot flags, tick stores, duration scaling, tick scan and output register.
// ----------------------------------------------------------------------------
module tpool_dp #(
   parameter int USED    = tpool_pkg::SLOTS_DEF,
   parameter int TICK_MS = tpool_pkg::TICK_MS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tpool_pkg::cmd_type              cmd,
   output tpool_pkg::stat_type             stat,
   input  tpool_pkg::func_type             req_func,
   input  logic [tpool_pkg::SLOT_W-1:0]    req_handle,
   input  logic [tpool_pkg::DUR_W-1:0]     req_duration_ms,
   input  logic                            req_periodic,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tpool_pkg::kind_type             rsp_kind,
   output logic [tpool_pkg::SLOT_W-1:0]    rsp_slot,
   output logic                            rsp_last
);

   localparam int IDX_W = $clog2(USED);
   localparam int CNT_W = $clog2(USED + 1);
   localparam int TW    = tpool_pkg::TICK_W;
   localparam int DW    = tpool_pkg::DUR_W;
   localparam int SW    = tpool_pkg::SLOT_W;
   localparam int CW    = tpool_pkg::DCNT_W;
   // ceil(ms / TICK_MS) = floor((ms + TICK_MS - 1) / TICK_MS), taken as
   // (x * RECIP) >> SH, exact for every x below 2^XW
   localparam int XW    = DW + 1;
   localparam int LW    = $clog2(TICK_MS);
   localparam int SH    = XW + LW;
   localparam int MW    = XW + 1;
   localparam int DIG_W = 8;
   localparam int NDIG  = (XW + DIG_W - 1) / DIG_W;
   localparam int XPW   = NDIG * DIG_W;
   localparam int AW    = XPW + MW;
   localparam int QW    = XW + 1;
   localparam logic [63:0] RECIP_L =
      ((64'd1 << SH) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
   localparam logic [MW-1:0] RECIP    = RECIP_L[MW-1:0];
   localparam logic [CW-1:0] DCNT_END = CW'(NDIG - 1);

   // latched request fields
   tpool_pkg::func_type func_ff;
   logic [SW-1:0]       handle_ff;
   logic                per_ff;

   // slot flags
   logic [USED-1:0] active_ff, active_in;
   logic [USED-1:0] periodic_ff, periodic_in;

   // reciprocal multiply and free-slot search
   logic [XPW-1:0]   x_ff;
   logic [AW-1:0]    acc_ff;
   logic [CW-1:0]    dcnt_ff;
   logic             div_busy_ff;
   logic             free_found;
   logic [IDX_W-1:0] free_idx;

   // tick scan
   logic [CNT_W-1:0] scan_cnt_ff;
   logic             ev_valid_ff;
   logic [IDX_W-1:0] ev_idx_ff;
   logic             pend_valid_ff;
   logic [IDX_W-1:0] pend_idx_ff;

   // output register
   logic                out_valid_ff;
   tpool_pkg::kind_type out_kind_ff;
   logic [SW-1:0]       out_slot_ff;
   logic                out_last_ff;

   logic                emit;
   tpool_pkg::kind_type emit_kind;
   logic [SW-1:0]       emit_slot;
   logic                emit_last;

   // multiply step
   logic [XW-1:0]         x_init;
   logic [DIG_W+MW-1:0]   part_prod;

   // tick count of a start
   logic [QW-1:0]    quot;
   logic [TW-1:0]    ticks;

   logic             out_free;
   logic             h_ok, h_act;
   logic [IDX_W-1:0] h_idx;
   logic             scan_more, ev_act, ev_exp, stall, advance;

   // RAM ports
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             per_wr_en;
   logic [IDX_W-1:0] per_wr_addr;
   logic [TW-1:0]    per_wr_data, per_rd;
   logic             rem_wr_en;
   logic [IDX_W-1:0] rem_wr_addr;
   logic [TW-1:0]    rem_wr_data, rem_rd;

   tpool_ram #(.WIDTH(TW), .DEPTH(USED)) u_period_ram (
      .clock   (clock),
      .wr_en   (per_wr_en),
      .wr_addr (per_wr_addr),
      .wr_data (per_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (per_rd)
   );

   tpool_ram #(.WIDTH(TW), .DEPTH(USED)) u_remain_ram (
      .clock   (clock),
      .wr_en   (rem_wr_en),
      .wr_addr (rem_wr_addr),
      .wr_data (rem_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rem_rd)
   );

   assign out_free = !out_valid_ff || rsp_ready;

   // one 8-bit digit of x per cycle, most significant first
   assign x_init    = {1'b0, req_duration_ms} + XW'(TICK_MS - 1);
   assign part_prod = x_ff[XPW-1 -: DIG_W] * RECIP;
   assign quot      = QW'(acc_ff >> SH);

   // zero duration is one tick, then clamp
   always_comb begin
      if (quot == '0) begin
         ticks = TW'(1);
      end else if (quot > QW'(tpool_pkg::TICK_MAX)) begin
         ticks = tpool_pkg::TICK_MAX;
      end else begin
         ticks = quot[TW-1:0];
      end
   end

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = USED - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign h_ok  = 32'(handle_ff) < USED;
   assign h_idx = handle_ff[IDX_W-1:0];
   assign h_act = h_ok && active_ff[h_idx];

   assign scan_more = 32'(scan_cnt_ff) < USED;
   assign ev_act    = active_ff[ev_idx_ff];
   assign ev_exp    = ev_valid_ff && ev_act && (rem_rd[TW-1:1] == '0);
   // a second expiry needs the held one out of the way first
   assign stall     = ev_exp && pend_valid_ff && !out_free;
   assign advance   = cmd.scan_run && !stall;

   assign rd_en   = cmd.op_read || (advance && scan_more);
   assign rd_addr = cmd.op_read ? h_idx : scan_cnt_ff[IDX_W-1:0];

   always_comb begin
      active_in   = active_ff;
      periodic_in = periodic_ff;
      per_wr_en   = 1'b0;
      per_wr_addr = free_idx;
      per_wr_data = ticks;
      rem_wr_en   = 1'b0;
      rem_wr_addr = free_idx;
      rem_wr_data = ticks;
      emit        = 1'b0;
      emit_kind   = tpool_pkg::KIND_ERROR;
      emit_slot   = '0;
      emit_last   = 1'b1;

      if (cmd.do_start) begin
         emit = 1'b1;
         if (free_found) begin
            active_in[free_idx]   = 1'b1;
            periodic_in[free_idx] = per_ff;
            per_wr_en = 1'b1;
            rem_wr_en = 1'b1;
            emit_kind = tpool_pkg::KIND_STARTED;
            emit_slot = SW'(free_idx);
         end
      end

      if (cmd.do_op) begin
         emit      = 1'b1;
         emit_slot = handle_ff;
         if (h_act) begin
            if (func_ff == tpool_pkg::FUNC_STOP) begin
               active_in[h_idx] = 1'b0;
               emit_kind        = tpool_pkg::KIND_STOPPED;
            end else begin
               rem_wr_en   = 1'b1;
               rem_wr_addr = h_idx;
               rem_wr_data = per_rd;
               emit_kind   = tpool_pkg::KIND_RESTARTED;
            end
         end
      end

      if (advance && ev_valid_ff && ev_act) begin
         rem_wr_addr = ev_idx_ff;
         if (ev_exp) begin
            if (periodic_ff[ev_idx_ff]) begin
               rem_wr_en   = 1'b1;
               rem_wr_data = per_rd;
            end else begin
               active_in[ev_idx_ff] = 1'b0;
            end
            if (pend_valid_ff) begin
               emit      = 1'b1;
               emit_kind = tpool_pkg::KIND_EXPIRED;
               emit_slot = SW'(pend_idx_ff);
               emit_last = 1'b0;
            end
         end else begin
            rem_wr_en   = 1'b1;
            rem_wr_data = rem_rd - TW'(1);
         end
      end

      if (cmd.flush) begin
         emit      = 1'b1;
         emit_kind = tpool_pkg::KIND_EXPIRED;
         emit_slot = SW'(pend_idx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         periodic_ff   <= '0;
         div_busy_ff   <= 1'b0;
         ev_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         scan_cnt_ff   <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         active_ff   <= active_in;
         periodic_ff <= periodic_in;

         if (cmd.div_start) begin
            div_busy_ff <= 1'b1;
         end else if (div_busy_ff && (dcnt_ff == DCNT_END)) begin
            div_busy_ff <= 1'b0;
         end

         if (cmd.scan_start) begin
            scan_cnt_ff   <= '0;
            ev_valid_ff   <= 1'b0;
            pend_valid_ff <= 1'b0;
         end else begin
            if (advance) begin
               ev_valid_ff <= scan_more;
               scan_cnt_ff <= scan_cnt_ff + CNT_W'(scan_more);
               if (ev_exp) begin
                  pend_valid_ff <= 1'b1;
               end
            end
            if (cmd.flush) begin
               pend_valid_ff <= 1'b0;
            end
         end

         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff   <= req_func;
         handle_ff <= req_handle;
         per_ff    <= req_periodic;
      end
      if (cmd.div_start) begin
         x_ff    <= XPW'(x_init);
         acc_ff  <= '0;
         dcnt_ff <= '0;
      end else if (div_busy_ff) begin
         x_ff    <= x_ff << DIG_W;
         acc_ff  <= (acc_ff << DIG_W) + AW'(part_prod);
         dcnt_ff <= dcnt_ff + CW'(1);
      end
      if (advance) begin
         ev_idx_ff <= scan_cnt_ff[IDX_W-1:0];
         if (ev_exp) begin
            pend_idx_ff <= ev_idx_ff;
         end
      end
      if (emit) begin
         out_kind_ff <= emit_kind;
         out_slot_ff <= emit_slot;
         out_last_ff <= emit_last;
      end
   end

   assign stat.div_busy   = div_busy_ff;
   assign stat.out_free   = out_free;
   assign stat.scan_done  = !scan_more && !ev_valid_ff;
   assign stat.pend_valid = pend_valid_ff;

   assign rsp_valid = out_valid_ff;
   assign rsp_kind  = out_kind_ff;
   assign rsp_slot  = out_slot_ff;
   assign rsp_last  = out_last_ff;

endmodule
